>>> rtl/ffaa_pkg.sv
// Shared types, constants and codes for the first-fit arena allocator.
// No dependencies; used by ffaa_ram users and the top level.
package ffaa_pkg;

    localparam int ARENA_BYTES   = 16384;
    localparam int HEADER_BYTES  = 16;
    localparam int GRANULE_BYTES = 8;

    // byte position within the arena, able to hold the arena end itself
    localparam int POS_W   = $clog2(ARENA_BYTES) + 1;
    localparam int SIZE_W  = POS_W;
    localparam int SEQ_W   = 32;
    localparam int HDR_W   = SIZE_W + 1 + SEQ_W;
    localparam int GSH     = $clog2(GRANULE_BYTES);
    localparam int DEPTH   = ARENA_BYTES / GRANULE_BYTES;
    localparam int IDX_W   = $clog2(DEPTH);
    // rounded request: limit register is 15 bits, so need never passes 2^15
    localparam int NEED_W  = 17;
    localparam int CMP_W   = 20;
    localparam int LIMIT_W = 15;
    localparam int PADDR_W = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1024;
    localparam logic [PADDR_W-1:0] ADDR_LIMIT  = 3'd0;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_OUTSIDE   = 3'd4;
    localparam logic [2:0] ST_RELEASED  = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] item_count;
        logic [15:0] item_bytes;
        logic [15:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] data_offset;
        logic [14:0] granted_bytes;
        logic [14:0] free_total;
        logic [14:0] largest_free;
        logic [31:0] order_breaks;
    } t_out_item;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              free;
        logic [SEQ_W-1:0]  seq;
    } t_hdr;

endpackage

>>> rtl/ffaa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/first_fit_arena_allocator_top.sv
// First-fit arena allocator top: sequencer walking block headers in a RAM.
// One item at a time; ready only when idle. Each header walk takes a read and a data
// state per block. An allocate takes one find walk plus one merge/statistics walk, a
// release adds an order-check walk; a report or an item refused up front only the merge walk.
// Reset: synchronous, clears control; the header RAM is not swept, entry 0 reads as
// the whole-arena free block until first written. Depends on ffaa_pkg, ffaa_ram.
module first_fit_arena_allocator_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  ffaa_pkg::t_in_item      i_in_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output ffaa_pkg::t_out_item     o_out_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ffaa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import ffaa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_DATA  = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [1:0] P_FIND  = 2'd0;
    localparam logic [1:0] P_ORDER = 2'd1;
    localparam logic [1:0] P_SCAN  = 2'd2;

    localparam logic [CMP_W-1:0] C_ARENA = CMP_W'(ARENA_BYTES);
    localparam logic [CMP_W-1:0] C_HDR   = CMP_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0] C_GRAN  = CMP_W'(GRANULE_BYTES);

    logic [2:0]         r_state;
    logic [1:0]         r_pass;
    logic [POS_W-1:0]   r_pos;
    t_in_item           r_item;
    logic [31:0]        r_total;
    logic [NEED_W-1:0]  r_need;
    logic [SEQ_W-1:0]   r_nseq;
    logic [31:0]        r_brk;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_hdr0_ok;
    logic [2:0]         r_status;
    logic [POS_W-1:0]   r_off;
    logic [SIZE_W-1:0]  r_grant;
    logic [POS_W-1:0]   r_rel_pos;
    t_hdr               r_rel_hdr;
    logic               r_hit;
    logic               r_run;
    logic               r_run_merged;
    logic [POS_W-1:0]   r_run_pos;
    logic [SIZE_W-1:0]  r_run_size;
    logic [SEQ_W-1:0]   r_run_seq;
    logic [POS_W-1:0]   r_ftot;
    logic [SIZE_W-1:0]  r_flarge;
    t_out_item          r_out;

    logic [HDR_W-1:0]   ram_rdata;
    logic               c_we;
    logic [IDX_W-1:0]   c_waddr;
    t_hdr               c_wdata;
    logic [IDX_W-1:0]   c_ridx;
    t_hdr               d;

    logic [CMP_W-1:0]   c_next;
    logic               c_last;
    logic               c_fit;
    logic               c_split;
    logic [CMP_W-1:0]   c_rem_pos;
    logic [SEQ_W-1:0]   c_seq1;
    logic               c_hit;
    logic [SIZE_W-1:0]  c_run_new;
    logic               c_close;
    logic [SIZE_W-1:0]  c_close_size;
    logic [POS_W-1:0]   c_ftot;
    logic [SIZE_W-1:0]  c_flarge;
    logic [NEED_W-1:0]  c_need;
    logic               c_cfg_wr;

    function automatic logic [IDX_W-1:0] pos_idx(input logic [CMP_W-1:0] p);
        pos_idx = p[IDX_W+GSH-1:GSH];
    endfunction

    assign c_ridx = pos_idx(CMP_W'(r_pos));

    ffaa_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_raddr(c_ridx),
        .o_rdata(ram_rdata)
    );

    // entry 0 holds the whole free arena until first written
    always_comb begin
        if (c_ridx == '0 && !r_hdr0_ok) begin
            d.size = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
            d.free = 1'b1;
            d.seq  = '0;
        end else begin
            d = t_hdr'(ram_rdata);
        end
    end

    always_comb begin
        c_next    = CMP_W'(r_pos) + C_HDR + CMP_W'(d.size);
        c_last    = c_next >= C_ARENA;
        c_fit     = d.free && (CMP_W'(d.size) >= CMP_W'(r_need));
        c_split   = CMP_W'(d.size) >= CMP_W'(r_need) + C_HDR + C_GRAN;
        c_rem_pos = CMP_W'(r_pos) + C_HDR + CMP_W'(r_need);
        c_seq1    = r_nseq + 1'b1;
        c_hit     = (r_pos != r_rel_pos) && !d.free && (d.seq > r_rel_hdr.seq);
        c_run_new = r_run ? SIZE_W'(CMP_W'(r_run_size) + C_HDR + CMP_W'(d.size)) : d.size;
        c_need    = (NEED_W'(r_total[NEED_W-1:0]) + NEED_W'(GRANULE_BYTES - 1))
                    & ~NEED_W'(GRANULE_BYTES - 1);
    end

    // run closing during the merge walk
    always_comb begin
        c_close      = 1'b0;
        c_close_size = r_run_size;
        if (d.free) begin
            if (c_last) begin
                c_close      = 1'b1;
                c_close_size = c_run_new;
            end
        end else if (r_run) begin
            c_close = 1'b1;
        end
        c_ftot   = r_ftot;
        c_flarge = r_flarge;
        if (c_close) begin
            c_ftot = POS_W'(CMP_W'(r_ftot) + CMP_W'(c_close_size));
            if (c_close_size > r_flarge) begin
                c_flarge = c_close_size;
            end
        end
    end

    // header writes
    always_comb begin
        c_we    = 1'b0;
        c_waddr = pos_idx(CMP_W'(r_pos));
        c_wdata = d;
        if (r_state == S_SPLIT) begin
            c_we         = 1'b1;
            c_wdata.size = SIZE_W'(r_need);
            c_wdata.free = 1'b0;
            c_wdata.seq  = r_nseq;
        end else if (r_state == S_DATA) begin
            unique case (r_pass)
                P_FIND: begin
                    if (r_item.action == ACT_ALLOC && c_fit) begin
                        c_we = 1'b1;
                        if (c_split) begin
                            c_waddr      = pos_idx(c_rem_pos);
                            c_wdata.size = SIZE_W'(CMP_W'(d.size) - CMP_W'(r_need) - C_HDR);
                            c_wdata.free = 1'b1;
                            c_wdata.seq  = '0;
                        end else begin
                            c_wdata.free = 1'b0;
                            c_wdata.seq  = c_seq1;
                        end
                    end
                end
                P_ORDER: begin
                    if (c_last) begin
                        c_we         = 1'b1;
                        c_waddr      = pos_idx(CMP_W'(r_rel_pos));
                        c_wdata      = r_rel_hdr;
                        c_wdata.free = 1'b1;
                    end
                end
                P_SCAN: begin
                    // write back the head of a run that absorbed neighbors
                    if (c_close && (d.free ? r_run : r_run_merged)) begin
                        c_we         = 1'b1;
                        c_waddr      = pos_idx(CMP_W'(r_run_pos));
                        c_wdata.size = c_close_size;
                        c_wdata.free = 1'b1;
                        c_wdata.seq  = r_run_seq;
                    end
                end
                default: c_we = 1'b0;
            endcase
        end
    end

    assign c_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pass    <= P_FIND;
            r_nseq    <= '0;
            r_brk     <= '0;
            r_limit   <= LIMIT_RESET;
            r_hdr0_ok <= 1'b0;
            r_run     <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (c_cfg_wr && paddr == ADDR_LIMIT) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
            if (c_we && c_waddr == '0) begin
                r_hdr0_ok <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item   <= i_in_data;
                        r_total  <= 32'(i_in_data.item_count) * 32'(i_in_data.item_bytes);
                        r_off    <= '0;
                        r_grant  <= '0;
                        r_status <= ST_GRANTED;
                        r_state  <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_pos   <= '0;
                    r_state <= S_RD;
                    r_pass  <= P_SCAN;
                    r_run   <= 1'b0;
                    r_ftot  <= '0;
                    r_flarge <= '0;
                    r_hit   <= 1'b0;
                    unique case (r_item.action)
                        ACT_ALLOC: begin
                            if (r_total == '0) begin
                                r_status <= ST_ZERO;
                            end else if (r_total >= 32'(r_limit)) begin
                                r_status <= ST_TOO_LARGE;
                            end else begin
                                r_need <= c_need;
                                r_pass <= P_FIND;
                            end
                        end
                        ACT_RELEASE: begin
                            if (CMP_W'(r_item.release_address) >= C_ARENA) begin
                                r_status <= ST_OUTSIDE;
                            end else begin
                                r_pass <= P_FIND;
                            end
                        end
                        default: r_status <= ST_GRANTED;
                    endcase
                end
                S_RD: begin
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    r_state <= S_RD;
                    r_pos   <= POS_W'(c_next);
                    unique case (r_pass)
                        P_FIND: begin
                            if (r_item.action == ACT_ALLOC) begin
                                if (c_fit) begin
                                    r_nseq   <= c_seq1;
                                    r_off    <= POS_W'(CMP_W'(r_pos) + C_HDR);
                                    r_status <= ST_GRANTED;
                                    r_grant  <= c_split ? SIZE_W'(r_need) : d.size;
                                    r_pass   <= P_SCAN;
                                    if (c_split) begin
                                        // hold position to stamp the granted header
                                        r_pos   <= r_pos;
                                        r_state <= S_SPLIT;
                                    end else begin
                                        r_pos <= '0;
                                    end
                                end else if (c_last) begin
                                    r_status <= ST_EXHAUSTED;
                                    r_pass   <= P_SCAN;
                                    r_pos    <= '0;
                                end
                            end else begin
                                if (CMP_W'(r_pos) + C_HDR == CMP_W'(r_item.release_address))
                                begin
                                    r_rel_pos <= r_pos;
                                    r_rel_hdr <= d;
                                    r_pass    <= P_ORDER;
                                    r_pos     <= '0;
                                end else if (c_last) begin
                                    r_status <= ST_OUTSIDE;
                                    r_pass   <= P_SCAN;
                                    r_pos    <= '0;
                                end
                            end
                        end
                        P_ORDER: begin
                            if (c_hit) begin
                                r_hit <= 1'b1;
                            end
                            if (c_last) begin
                                if (r_hit || c_hit) begin
                                    r_brk <= r_brk + 1'b1;
                                end
                                r_status <= ST_RELEASED;
                                r_pass   <= P_SCAN;
                                r_pos    <= '0;
                            end
                        end
                        P_SCAN: begin
                            r_ftot   <= c_ftot;
                            r_flarge <= c_flarge;
                            if (d.free) begin
                                r_run      <= 1'b1;
                                r_run_size <= c_run_new;
                                r_run_merged <= r_run;
                                if (!r_run) begin
                                    r_run_pos <= r_pos;
                                    r_run_seq <= d.seq;
                                end
                            end else begin
                                r_run <= 1'b0;
                            end
                            if (c_last) begin
                                r_out.status        <= r_status;
                                r_out.data_offset   <= r_off[13:0];
                                r_out.granted_bytes <= 15'(r_grant);
                                r_out.free_total    <= 15'(c_ftot);
                                r_out.largest_free  <= 15'(c_flarge);
                                r_out.order_breaks  <= r_brk;
                                r_run               <= 1'b0;
                                r_state             <= S_OUT;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_SPLIT: begin
                    r_pos   <= '0;
                    r_state <= S_RD;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_out_data = r_out;
    assign pready     = 1'b1;
    assign prdata     = (paddr == ADDR_LIMIT) ? 32'(r_limit) : 32'd0;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result is pending");

    a_grant_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_data.status == ST_GRANTED && r_item.action == ACT_ALLOC)
        |-> (o_out_data.granted_bytes != '0))
        else $error("grant without bytes");

    a_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_data.largest_free <= o_out_data.free_total))
        else $error("largest free block exceeds free total");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

endmodule
